/* hdl/i2p_pkg.sv */
// Package: operator codes, character classes, sequencer states and helpers.
package i2p_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic [7:0] CH_OPEN   = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE  = 8'h29;  // ')'
  localparam logic [7:0] CH_TIMES  = 8'h2A;  // '*'
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_DIVIDE = 8'h2F;  // '/'
  localparam logic [7:0] CH_UPPER_LO = 8'd64;   // letters lie strictly between these
  localparam logic [7:0] CH_UPPER_HI = 8'd91;
  localparam logic [7:0] CH_LOWER_LO = 8'd96;
  localparam logic [7:0] CH_LOWER_HI = 8'd123;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_PLUS   = 3'd1,
    OP_MINUS  = 3'd2,
    OP_TIMES  = 3'd3,
    OP_DIVIDE = 3'd4,
    OP_OPEN   = 3'd5
  } op_code_t;

  typedef enum logic [2:0] {
    CL_OTHER,
    CL_LETTER,
    CL_OPEN,
    CL_CLOSE,
    CL_OPER
  } char_class_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_OP_POP,
    ST_CLOSE_POP,
    ST_TAIL,
    ST_FINISH
  } state_t;

  function automatic op_code_t char_to_op(input logic [7:0] ch);
    op_code_t code;
    unique case (ch)
      CH_PLUS:   code = OP_PLUS;
      CH_MINUS:  code = OP_MINUS;
      CH_TIMES:  code = OP_TIMES;
      CH_DIVIDE: code = OP_DIVIDE;
      default:   code = OP_NONE;
    endcase
    return code;
  endfunction

  function automatic char_class_t classify(input logic [7:0] ch);
    char_class_t cls;
    if (ch == CH_OPEN) begin
      cls = CL_OPEN;
    end else if ((ch > CH_UPPER_LO && ch < CH_UPPER_HI) ||
                 (ch > CH_LOWER_LO && ch < CH_LOWER_HI)) begin
      cls = CL_LETTER;
    end else if (char_to_op(ch) != OP_NONE) begin
      cls = CL_OPER;
    end else if (ch == CH_CLOSE) begin
      cls = CL_CLOSE;
    end else begin
      cls = CL_OTHER;
    end
    return cls;
  endfunction

  function automatic logic [1:0] op_prio(input op_code_t code);
    logic [1:0] p;
    unique case (code)
      OP_PLUS, OP_MINUS:   p = 2'd1;
      OP_TIMES, OP_DIVIDE: p = 2'd2;
      default:             p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] op_to_char(input op_code_t code);
    logic [7:0] ch;
    unique case (code)
      OP_PLUS:   ch = CH_PLUS;
      OP_MINUS:  ch = CH_MINUS;
      OP_TIMES:  ch = CH_TIMES;
      OP_DIVIDE: ch = CH_DIVIDE;
      default:   ch = CH_OPEN;
    endcase
    return ch;
  endfunction

endpackage

/* hdl/i2p_if.sv */
// Interfaces: character input channel and postfix result channel.
interface i2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       expr_last;

  modport source (output valid, output in_char, output expr_last, input ready);
  modport sink   (input valid, input in_char, input expr_last, output ready);
endinterface

interface i2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       has_char;
  logic       run_last;
  logic       expr_end;
  logic       overflow_seen;

  modport source (output valid, output out_char, output has_char, output run_last,
                  output expr_end, output overflow_seen, input ready);
  modport sink   (input valid, input out_char, input has_char, input run_last,
                  input expr_end, input overflow_seen, output ready);
endinterface

/* hdl/infix_to_postfix_converter.sv */
// Top level: shunting-yard infix to postfix converter with an operator stack.
//
// Usage:
//  - in_if carries one ASCII character per transaction plus expr_last, which
//    marks the final character of an expression; the stack is flushed after it.
//  - out_if carries one postfix character per transaction. run_last flags the
//    last result caused by an input character, expr_end the final result of an
//    expression. A last character that emits nothing yields one marker result
//    with has_char low. overflow_seen is the sticky stack overflow flag.
//  - Timing: in_if.ready is low while a character is processed. A letter, '('
//    or ignored character passes dispatch, tail and finish; an operator or ')'
//    also passes a pop state, pushing the operator or dropping the '('. Each
//    stack pop adds a step; the stack walk takes one entry per cycle unless stalled.
//  - A result waits in a pending register until the next one is produced, or
//    until the finish cycle for the last one, so run_last is known on output.
//  - Receiver stall: the output register holds its transaction; the sequencer
//    waits in place when a new result finds pending and output both occupied.
//  - Reset (rst_n low, synchronous): stack empty, overflow flag clear, no
//    pending or output transaction; in_if.ready is high from the first cycle after.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  i2p_in_if.sink    in_if,
  i2p_out_if.source out_if
);
  import i2p_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);  // count width
  localparam int unsigned AW = $clog2(STACK_DEPTH);      // stack address width

  // Sequencer and item registers
  state_t      state_r, state_nxt;
  logic [7:0]  ch_r;
  logic        last_r;

  // Stack: top entry in a register, the one below prefetched, rest in memory
  op_code_t    stack_mem [STACK_DEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt;
  op_code_t    top_r, top_nxt;
  op_code_t    below_r;
  logic        ovf_r, ovf_nxt;

  // Pending result (one behind) and output register
  logic        pend_v_r, pend_v_nxt;
  logic [7:0]  pend_char_r, pend_char_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic        out_has_r, out_has_nxt;
  logic        out_rlast_r, out_rlast_nxt;
  logic        out_end_r, out_end_nxt;
  logic        out_ovf_r, out_ovf_nxt;

  // Sequencer controls
  logic        in_fire;
  logic        out_free;
  logic        emit_ok;
  logic        do_emit;
  logic [7:0]  emit_char;
  logic        do_pop;
  logic        do_push;
  logic        push_ok;
  op_code_t    push_code;
  logic        do_close;
  logic        stack_nonempty;
  op_code_t    cur_op;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m3;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign in_if.ready = rst_n && (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign emit_ok     = !pend_v_r || out_free;  // room to push the pending result out
  assign stack_nonempty = (cnt_r != '0);
  assign cur_op      = char_to_op(ch_r);

  assign cnt_m1  = cnt_r - CW'(1);
  assign cnt_m3  = cnt_r - CW'(3);
  assign wr_addr = cnt_m1[AW-1:0];
  assign rd_addr = cnt_m3[AW-1:0];   // new "below" after a pop; unused when count < 3
  assign push_ok = do_push && (cnt_r != CW'(STACK_DEPTH));

  // Sequencer: next state and step controls
  always_comb begin
    state_nxt = state_r;
    do_emit   = 1'b0;
    emit_char = op_to_char(top_r);
    do_pop    = 1'b0;
    do_push   = 1'b0;
    push_code = cur_op;
    do_close  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (classify(ch_r))
          CL_OPEN: begin
            do_push   = 1'b1;
            push_code = OP_OPEN;
            state_nxt = ST_TAIL;
          end
          CL_LETTER: begin
            if (emit_ok) begin
              do_emit   = 1'b1;
              emit_char = ch_r;
              state_nxt = ST_TAIL;
            end
          end
          CL_OPER:  state_nxt = ST_OP_POP;
          CL_CLOSE: state_nxt = ST_CLOSE_POP;
          default:  state_nxt = ST_TAIL;
        endcase
      end
      ST_OP_POP: begin
        if (stack_nonempty && (op_prio(top_r) >= op_prio(cur_op))) begin
          if (emit_ok) begin
            do_emit = 1'b1;
            do_pop  = 1'b1;
          end
        end else begin
          do_push   = 1'b1;
          state_nxt = ST_TAIL;
        end
      end
      ST_CLOSE_POP: begin
        if (stack_nonempty && (top_r != OP_OPEN)) begin
          if (emit_ok) begin
            do_emit = 1'b1;
            do_pop  = 1'b1;
          end
        end else begin
          do_pop    = stack_nonempty;  // discard the matching '('
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (last_r && stack_nonempty) begin
          if (emit_ok) begin
            do_emit = 1'b1;
            do_pop  = 1'b1;
          end
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (pend_v_r || last_r) begin
          if (out_free) begin
            do_close  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Stack count, top and overflow
  always_comb begin
    cnt_nxt = cnt_r;
    top_nxt = top_r;
    ovf_nxt = ovf_r;
    if (do_push) begin
      if (push_ok) begin
        cnt_nxt = cnt_r + CW'(1);
        top_nxt = push_code;
      end else begin
        ovf_nxt = 1'b1;
      end
    end else if (do_pop) begin
      cnt_nxt = cnt_m1;
      top_nxt = below_r;
    end
  end

  // Pending slot and output register
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_char_nxt = pend_char_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_char_nxt  = out_char_r;
    out_has_nxt   = out_has_r;
    out_rlast_nxt = out_rlast_r;
    out_end_nxt   = out_end_r;
    out_ovf_nxt   = out_ovf_r;
    if (do_emit) begin
      pend_v_nxt    = 1'b1;
      pend_char_nxt = emit_char;
    end
    if (do_close) begin
      pend_v_nxt = 1'b0;
    end
    if ((do_emit && pend_v_r) || do_close) begin
      out_valid_nxt = 1'b1;
      out_ovf_nxt   = ovf_r;
      out_rlast_nxt = do_close;
      out_end_nxt   = do_close && last_r;
      if (pend_v_r) begin
        out_char_nxt = pend_char_r;
        out_has_nxt  = 1'b1;
      end else begin
        // empty end-of-expression marker
        out_char_nxt = '0;
        out_has_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r   <= in_if.in_char;
      last_r <= in_if.expr_last;
    end
    top_r       <= top_nxt;
    pend_char_r <= pend_char_nxt;
    out_char_r  <= out_char_nxt;
    out_has_r   <= out_has_nxt;
    out_rlast_r <= out_rlast_nxt;
    out_end_r   <= out_end_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // Stack memory: old top spills on push, next-below is read on pop
  always_ff @(posedge clk) begin
    if (push_ok && stack_nonempty) begin
      stack_mem[wr_addr] <= top_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      below_r <= top_r;
    end else if (do_pop) begin
      below_r <= stack_mem[rd_addr];
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.out_char      = out_char_r;
  assign out_if.has_char      = out_has_r;
  assign out_if.run_last      = out_rlast_r;
  assign out_if.expr_end      = out_end_r;
  assign out_if.overflow_seen = out_ovf_r;

endmodule

/* hdl/i2p_checker.sv */
// Checker: port-level properties of the converter, bound to the top level.
module i2p_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       has_char,
  input logic       run_last,
  input logic       expr_end,
  input logic       overflow_seen
);

  logic ovf_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_seen_r <= 1'b0;
    end else if (out_valid && out_ready && overflow_seen) begin
      ovf_seen_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && expr_end |-> run_last)
    else $error("expr_end without run_last");

  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_char |-> run_last && expr_end && (out_char == 8'd0))
    else $error("malformed end-of-expression marker");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ovf_seen_r |-> overflow_seen)
    else $error("overflow flag cleared after being reported");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_char      (out_if.out_char),
  .has_char      (out_if.has_char),
  .run_last      (out_if.run_last),
  .expr_end      (out_if.expr_end),
  .overflow_seen (out_if.overflow_seen)
);
